### rtl/signed_int_to_decimal_ascii_defines.svh
// Assertion macros for the signed integer to decimal ASCII block
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SID_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sid assertion failed");

// next-cycle implication, checked out of reset
`define SID_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sid assertion failed");

`endif

### rtl/sid_pkg.sv
// Shared constants and types for the signed integer to decimal ASCII block
package sid_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    typedef struct packed {
        logic clear;
        logic convert;
        logic shift;
    } cell_ctrl_t;

endpackage

### rtl/signed_int_to_decimal_ascii.sv
// Top level: signed binary integer to decimal ASCII characters
//
//  channel   ports                          direction  beat
//  input     s_valid s_ready s_value        in         one integer
//  output    m_valid m_ready m_character    out        one character, m_last on final
//            m_last
//
//  Per integer: load, double-dabble conversion of the magnitude bit by bit, dropping of
//  leading zeros, then the characters in order, a minus sign first if negative.
//  The next integer is accepted once the final character sits in the output register.
//  aresetn is synchronous, active low, and clears the control state only.
//  m_ready low holds the output register and freezes the digit row, adding its cycles.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sid_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_character,
    output logic                  m_last
);

    `include "signed_int_to_decimal_ascii_defines.svh"

    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CW     = $clog2(VALUE_BITS);
    localparam int RW     = $clog2(DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [RW-1:0]         remain_reg, remain_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_character_reg, m_character_next;
    logic                  m_last_reg, m_last_next;

    sid_pkg::cell_ctrl_t   ctrl;
    logic [3:0]            top_digit;
    logic                  out_free;
    logic                  in_beat;

    sid_chain #(
        .DIGITS (DIGITS)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .serial_in (mag_reg[VALUE_BITS-1]),
        .top_digit (top_digit)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        remain_next      = remain_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        ctrl             = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    neg_next    = s_value[VALUE_BITS-1];
                    mag_next    = s_value[VALUE_BITS-1] ? ({VALUE_BITS{1'b0}} - s_value)
                                                        : s_value;
                    cnt_next    = '0;
                    remain_next = RW'(DIGITS);
                    ctrl.clear  = 1'b1;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV: begin
                ctrl.convert = 1'b1;
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(VALUE_BITS - 1)) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && remain_reg != RW'(1)) begin
                    ctrl.shift  = 1'b1;
                    remain_next = remain_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_character_next = sid_pkg::CHAR_MINUS;
                        m_last_next      = 1'b0;
                        neg_next         = 1'b0;
                    end else begin
                        m_character_next = sid_pkg::CHAR_ZERO + {4'd0, top_digit};
                        m_last_next      = (remain_reg == RW'(1));
                        ctrl.shift       = 1'b1;
                        remain_next      = remain_reg - 1'b1;
                        if (remain_reg == RW'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg         <= cnt_next;
        remain_reg      <= remain_next;
        neg_reg         <= neg_next;
        mag_reg         <= mag_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    `SID_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_ready)
    `SID_ASSERT_IMPLY(a_char_legal, m_valid,
        m_character == sid_pkg::CHAR_MINUS ||
        (m_character >= sid_pkg::CHAR_ZERO && m_character <= sid_pkg::CHAR_ZERO + 8'd9))
    `SID_ASSERT_IMPLY(a_last_is_digit, m_valid && m_last, m_character != sid_pkg::CHAR_MINUS)
    `SID_ASSERT_IMPLY(a_remain_nonzero, state_reg == ST_SKIP || state_reg == ST_EMIT,
        remain_reg != '0)

endmodule

### rtl/sid_cell.sv
// One BCD digit cell: double-dabble step, clear, and digit shift toward the top
module sid_cell (
    input  logic                aclk,
    input  sid_pkg::cell_ctrl_t ctrl,
    input  logic                carry_in,
    input  logic [3:0]          digit_in,
    output logic                carry_out,
    output logic [3:0]          digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb begin
        adj = (digit_reg >= sid_pkg::DABBLE_LIMIT) ? (digit_reg + sid_pkg::DABBLE_ADD)
                                                   : digit_reg;
    end

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = 4'd0;
        end else if (ctrl.convert) begin
            digit_next = {adj[2:0], carry_in};
        end else if (ctrl.shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign carry_out = adj[3];
    assign digit     = digit_reg;

endmodule

### rtl/sid_chain.sv
// Row of BCD digit cells, least significant cell first
module sid_chain #(
    parameter int DIGITS = 10
) (
    input  logic                aclk,
    input  sid_pkg::cell_ctrl_t ctrl,
    input  logic                serial_in,
    output logic [3:0]          top_digit
);

    logic [DIGITS:0] carry;
    logic [3:0]      digits [DIGITS+1];

    assign carry[0]  = serial_in;
    assign digits[0] = 4'd0;

    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        sid_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .carry_in  (carry[g]),
            .digit_in  (digits[g]),
            .carry_out (carry[g+1]),
            .digit     (digits[g+1])
        );
    end

    assign top_digit = digits[DIGITS];

    // the top carry stays zero while converting since the row holds the full magnitude
    logic unused_carry;
    assign unused_carry = carry[DIGITS];

endmodule
